// ===== hw/rtl/ble_finder_tag_classifier_core_assert.svh =====
// Assertion helpers used by the classifier core RTL.
`ifndef BLE_FINDER_TAG_CLASSIFIER_CORE_ASSERT_SVH
`define BLE_FINDER_TAG_CLASSIFIER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BLFTC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication, checked outside reset.
`define BLFTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// ===== hw/rtl/blftc_pkg.sv =====
package blftc_pkg;

    localparam int MaxSvcEntries  = 12;
    localparam int MaxPacketBytes = 255;
    localparam int SvcCntW        = $clog2(MaxSvcEntries + 1);
    localparam int PosW           = $clog2(MaxPacketBytes + 1);

    // element offset stops counting once past the last byte of interest
    localparam logic [2:0] OffSat = 3'd5;

    localparam logic [7:0]  AdTypeManuf  = 8'hFF;
    localparam logic [7:0]  AdTypeSvc16  = 8'h16;
    localparam logic [15:0] CompanyId    = 16'h004C;
    localparam logic [7:0]  CoSubtype    = 8'h12;
    localparam logic [7:0]  CoSepLen     = 8'h19;
    localparam logic [15:0] SvcUuidFeed  = 16'hFEED;
    localparam logic [15:0] SvcUuidFd5a  = 16'hFD5A;
    localparam logic [15:0] SvcUuidFeaa  = 16'hFEAA;
    localparam logic [7:0]  FeaaFrame    = 8'h41;
    localparam logic [7:0]  FeaaLenShort = 8'd24;
    localparam logic [7:0]  FeaaLenLong  = 8'd36;
    localparam logic [7:0]  MinIdData    = 8'd2;
    localparam logic [7:0]  MinSvcData   = 8'd4;

    localparam logic [6:0] ConfMfg  = 7'd85;
    localparam logic [6:0] ConfFeed = 7'd65;
    localparam logic [6:0] ConfFd5a = 7'd60;
    localparam logic [6:0] ConfFeaa = 7'd65;

    typedef enum logic [2:0] {
        KIND_NONE     = 3'd0,
        KIND_MFG_SEP  = 3'd1,
        KIND_SVC_FEED = 3'd2,
        KIND_SVC_FD5A = 3'd3,
        KIND_SVC_FEAA = 3'd4
    } t_kind;

    typedef enum logic {
        METHOD_MFG_ID   = 1'b0,
        METHOD_SVC_DATA = 1'b1
    } t_method;

    typedef struct packed {
        logic [7:0]        adv_byte;
        logic              last_byte;
        logic [47:0]       device_address;
        logic signed [7:0] signal_strength;
    } t_in_item;

    typedef struct packed {
        logic              detected;
        logic [2:0]        tracker_kind;
        logic              match_method;
        logic [6:0]        confidence;
        logic [47:0]       tag_address;
        logic signed [7:0] tag_strength;
    } t_out_item;

    // Packet flags after the current byte has been taken
    typedef struct packed {
        logic  beacon_hit;
        t_kind svc_kind;
    } t_flags;

endpackage

// ===== hw/rtl/blftc_parser.sv =====
module blftc_parser
    import blftc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic       i_last,
    input  logic [7:0] i_byte,
    output t_flags     o_flags
);

    logic [7:0]         r_left,  n_left;
    logic [7:0]         r_len,   n_len;
    logic [7:0]         r_type,  n_type;
    logic [2:0]         r_off,   n_off;
    logic [15:0]        r_uuid,  n_uuid;
    logic [7:0]         r_d2,    n_d2;
    logic [7:0]         r_d3,    n_d3;
    logic               r_mseen, n_mseen;
    logic               r_beacon, n_beacon;
    logic [SvcCntW-1:0] r_cnt,   n_cnt;
    t_kind              r_kind,  n_kind;
    logic               r_stop,  n_stop;
    logic [PosW-1:0]    r_pos,   n_pos;
    logic [7:0]         dlen;

    always_comb begin
        n_left   = r_left;
        n_len    = r_len;
        n_type   = r_type;
        n_off    = r_off;
        n_uuid   = r_uuid;
        n_d2     = r_d2;
        n_d3     = r_d3;
        n_mseen  = r_mseen;
        n_beacon = r_beacon;
        n_cnt    = r_cnt;
        n_kind   = r_kind;
        n_stop   = r_stop;
        n_pos    = r_pos;
        dlen     = r_len - 8'd1;
        if (i_step && (r_pos < PosW'(MaxPacketBytes))) begin
            n_pos = r_pos + PosW'(1);
            if (!r_stop) begin
                if (r_left == 8'd0) begin
                    if (i_byte == 8'd0) begin
                        n_stop = 1'b1;
                    end else begin
                        n_len  = i_byte;
                        n_left = i_byte;
                        n_off  = 3'd0;
                        n_type = 8'd0;
                        n_uuid = 16'd0;
                        n_d2   = 8'd0;
                        n_d3   = 8'd0;
                    end
                end else begin
                    case (r_off)
                        3'd0: n_type = i_byte;
                        3'd1: n_uuid = {r_uuid[15:8], i_byte};
                        3'd2: n_uuid = {i_byte, r_uuid[7:0]};
                        3'd3: n_d2 = i_byte;
                        3'd4: n_d3 = i_byte;
                        default: ;
                    endcase
                    if (r_off != OffSat) begin
                        n_off = r_off + 3'd1;
                    end
                    n_left = r_left - 8'd1;
                    // element complete: classify it
                    if (r_left == 8'd1) begin
                        if (n_type == AdTypeManuf && dlen >= MinIdData && !r_mseen) begin
                            n_mseen  = 1'b1;
                            n_beacon = (n_uuid == CompanyId) && (dlen >= MinSvcData) &&
                                       (n_d2 == CoSubtype) && (n_d3 == CoSepLen);
                        end else if (n_type == AdTypeSvc16 && dlen >= MinIdData &&
                                     r_cnt < SvcCntW'(MaxSvcEntries)) begin
                            n_cnt = r_cnt + SvcCntW'(1);
                            if (r_kind == KIND_NONE && dlen >= MinSvcData) begin
                                if (n_uuid == SvcUuidFeed) begin
                                    n_kind = KIND_SVC_FEED;
                                end else if (n_uuid == SvcUuidFd5a) begin
                                    n_kind = KIND_SVC_FD5A;
                                end else if (n_uuid == SvcUuidFeaa &&
                                             (dlen == FeaaLenShort || dlen == FeaaLenLong) &&
                                             n_d2 == FeaaFrame) begin
                                    n_kind = KIND_SVC_FEAA;
                                end
                            end
                        end
                    end
                end
            end
        end
    end

    assign o_flags = '{beacon_hit: n_beacon, svc_kind: n_kind};

    // Packet state is cleared once the last byte has been taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_left   <= '0;
            r_len    <= '0;
            r_type   <= '0;
            r_off    <= '0;
            r_uuid   <= '0;
            r_d2     <= '0;
            r_d3     <= '0;
            r_mseen  <= 1'b0;
            r_beacon <= 1'b0;
            r_cnt    <= '0;
            r_kind   <= KIND_NONE;
            r_stop   <= 1'b0;
            r_pos    <= '0;
        end else begin
            r_left   <= n_left;
            r_len    <= n_len;
            r_type   <= n_type;
            r_off    <= n_off;
            r_uuid   <= n_uuid;
            r_d2     <= n_d2;
            r_d3     <= n_d3;
            r_mseen  <= n_mseen;
            r_beacon <= n_beacon;
            r_cnt    <= n_cnt;
            r_kind   <= n_kind;
            r_stop   <= n_stop;
            r_pos    <= n_pos;
        end
    end

endmodule

// ===== hw/rtl/blftc_verdict.sv =====
module blftc_verdict
    import blftc_pkg::*;
(
    input  logic              i_scan_en,
    input  t_flags            i_flags,
    input  logic [47:0]       i_address,
    input  logic signed [7:0] i_strength,
    output t_out_item         o_item
);

    t_kind      kind;
    t_method    method;
    logic [6:0] conf;

    always_comb begin
        kind   = KIND_NONE;
        method = METHOD_MFG_ID;
        conf   = 7'd0;
        if (i_scan_en) begin
            if (i_flags.beacon_hit) begin
                kind   = KIND_MFG_SEP;
                method = METHOD_MFG_ID;
                conf   = ConfMfg;
            end else begin
                case (i_flags.svc_kind)
                    KIND_SVC_FEED: begin
                        kind   = KIND_SVC_FEED;
                        method = METHOD_SVC_DATA;
                        conf   = ConfFeed;
                    end
                    KIND_SVC_FD5A: begin
                        kind   = KIND_SVC_FD5A;
                        method = METHOD_SVC_DATA;
                        conf   = ConfFd5a;
                    end
                    KIND_SVC_FEAA: begin
                        kind   = KIND_SVC_FEAA;
                        method = METHOD_SVC_DATA;
                        conf   = ConfFeaa;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_item = '{
        detected:        (kind != KIND_NONE),
        tracker_kind:    kind,
        match_method:    method,
        confidence:      conf,
        tag_address:     i_address,
        tag_strength:    i_strength
    };

endmodule

// ===== hw/rtl/ble_finder_tag_classifier_core.sv =====
// Channel  Direction  Handshake                 Payload
// in       input      i_in_valid / o_in_ready   i_in_data  (t_in_item)
// out      output     o_out_valid / i_out_ready o_out_data (t_out_item)
// cfg      input      i_cfg_wr_en               i_cfg_wr_data (scan enable)
//
// One byte per cycle sustained while the output is not stalled; the input register and
// the parser update together form a single stage, so a byte can follow in the next cycle.
// A verdict is loaded into the output register while its last byte sits in the input
// register, unless the previous verdict is still held.
// Reset is synchronous and needs no clearing pass.
// A stalled output holds back only a last byte, and no new byte is taken while it waits; other bytes keep flowing.
module ble_finder_tag_classifier_core
    import blftc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data,
    input  logic      i_cfg_wr_en,
    input  logic      i_cfg_wr_data
);

`include "ble_finder_tag_classifier_core_assert.svh"

    logic      r_scan_en;
    logic      r_in_vld;
    t_in_item  r_in;
    logic      r_out_vld;
    t_out_item r_out;
    logic      out_free;
    logic      proc;
    logic      out_load;
    t_flags    flags;
    t_out_item verdict;

    assign out_free   = !r_out_vld || i_out_ready;
    assign proc       = r_in_vld && (!r_in.last_byte || out_free);
    assign out_load   = proc && r_in.last_byte;
    assign o_in_ready = !r_in_vld || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_en <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_scan_en <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    blftc_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (proc),
        .i_last  (r_in.last_byte),
        .i_byte  (r_in.adv_byte),
        .o_flags (flags)
    );

    blftc_verdict u_verdict (
        .i_scan_en  (r_scan_en),
        .i_flags    (flags),
        .i_address  (r_in.device_address),
        .i_strength (r_in.signal_strength),
        .o_item     (verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= verdict;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    `BLFTC_ASSERT_NOW(a_no_overwrite_in, i_clk, i_rst_n,
        i_in_valid && o_in_ready && r_in_vld, proc)
    `BLFTC_ASSERT_NEXT(a_result_kept, i_clk, i_rst_n,
        r_out_vld && !i_out_ready, r_out_vld)
    `BLFTC_ASSERT_NOW(a_detect_needs_scan, i_clk, i_rst_n,
        r_out_vld && r_out.detected, r_scan_en)
    `BLFTC_ASSERT_NOW(a_miss_is_clean, i_clk, i_rst_n,
        r_out_vld && !r_out.detected,
        r_out.tracker_kind == KIND_NONE && r_out.confidence == 7'd0 &&
        r_out.match_method == METHOD_MFG_ID)

endmodule

// ===== tb/ble_finder_tag_classifier_core_test.sv =====
package blftc_tb_pkg;
    import blftc_pkg::*;

    localparam logic [7:0]  TypeManuf      = 8'hFF;
    localparam logic [7:0]  TypeSvc16      = 8'h16;
    localparam logic [15:0] CoIdBeacon     = 16'h004C;
    localparam logic [7:0]  SepSubtype     = 8'h12;
    localparam logic [7:0]  SepLength      = 8'h19;
    localparam logic [15:0] UuidFeed       = 16'hFEED;
    localparam logic [15:0] UuidFd5a       = 16'hFD5A;
    localparam logic [15:0] UuidFeaa       = 16'hFEAA;
    localparam logic [7:0]  FeaaFrameType  = 8'h41;
    localparam int          SvcEntryLimit  = 12;
    localparam int          PacketLimit    = 255;
    localparam logic [6:0]  ConfBeaconPct  = 7'd85;
    localparam logic [6:0]  ConfServicePct = 7'd65;
    localparam logic [6:0]  ConfFd5aPct    = 7'd60;

    // Byte-level parser of the advertising stream, yielding one verdict per packet
    class ad_verdict_tracker;
        t_out_item   expected_verdicts[$];
        bit          scan_on;
        int unsigned mismatch_count;
        int unsigned verdict_count;
        int unsigned kind_seen[5];

        logic [7:0]  left_in_elem, elem_len, elem_type, elem_offset, pos;
        logic [15:0] uuid;
        logic [7:0]  data2, data3;
        bit          mfg_taken, beacon_found, parse_halted;
        logic [3:0]  svc_count;
        t_kind       svc_kind;

        function new();
            clear_packet();
        endfunction

        function void clear_packet();
            left_in_elem = '0;
            elem_len     = '0;
            elem_type    = '0;
            elem_offset  = '0;
            pos          = '0;
            uuid         = '0;
            data2        = '0;
            data3        = '0;
            mfg_taken    = 1'b0;
            beacon_found = 1'b0;
            parse_halted = 1'b0;
            svc_count    = '0;
            svc_kind     = KIND_NONE;
        endfunction

        function void close_element();
            int dlen;
            dlen = int'(elem_len) - 1;
            if (elem_type == TypeManuf && dlen >= 2 && !mfg_taken) begin
                // only the first manufacturer element counts
                mfg_taken    = 1'b1;
                beacon_found = (uuid == CoIdBeacon && dlen >= 4 &&
                                data2 == SepSubtype && data3 == SepLength);
            end else if (elem_type == TypeSvc16 && dlen >= 2 && svc_count < SvcEntryLimit) begin
                svc_count++;
                if (svc_kind == KIND_NONE && dlen >= 4) begin
                    if (uuid == UuidFeed)
                        svc_kind = KIND_SVC_FEED;
                    else if (uuid == UuidFd5a)
                        svc_kind = KIND_SVC_FD5A;
                    else if (uuid == UuidFeaa && (dlen == 24 || dlen == 36) &&
                             data2 == FeaaFrameType)
                        svc_kind = KIND_SVC_FEAA;
                end
            end
        endfunction

        function void parse_byte(logic [7:0] b);
            if (pos >= PacketLimit)
                return;
            pos++;
            if (parse_halted)
                return;
            if (left_in_elem == 0) begin
                if (b == 0) begin
                    parse_halted = 1'b1;
                end else begin
                    elem_len     = b;
                    left_in_elem = b;
                    elem_offset  = '0;
                    elem_type    = '0;
                    uuid         = '0;
                    data2        = '0;
                    data3        = '0;
                end
                return;
            end
            case (elem_offset)
                8'd0: elem_type = b;
                8'd1: uuid[7:0] = b;
                8'd2: uuid[15:8] = b;
                8'd3: data2 = b;
                8'd4: data3 = b;
                default: ;
            endcase
            if (elem_offset != 8'hFF)
                elem_offset++;
            left_in_elem--;
            if (left_in_elem == 0)
                close_element();
        endfunction

        function void take_item(t_in_item it);
            t_out_item v;
            parse_byte(it.adv_byte);
            if (!it.last_byte)
                return;
            v = '0;
            v.tag_address  = it.device_address;
            v.tag_strength = it.signal_strength;
            if (scan_on) begin
                if (beacon_found) begin
                    v.detected     = 1'b1;
                    v.tracker_kind = KIND_MFG_SEP;
                    v.match_method = METHOD_MFG_ID;
                    v.confidence   = ConfBeaconPct;
                end else if (svc_kind != KIND_NONE) begin
                    v.detected     = 1'b1;
                    v.tracker_kind = svc_kind;
                    v.match_method = METHOD_SVC_DATA;
                    v.confidence   = (svc_kind == KIND_SVC_FD5A) ? ConfFd5aPct : ConfServicePct;
                end
            end
            expected_verdicts.push_back(v);
            clear_packet();
        endfunction

        task note_mismatch(string what);
            if (mismatch_count < 40)
                $display("MISMATCH at %0t ns: %s", $time, what);
            mismatch_count++;
        endtask

        task compare_verdict(t_out_item got);
            t_out_item want;
            if (expected_verdicts.size() == 0) begin
                note_mismatch($sformatf("verdict %h with nothing pending", got));
                return;
            end
            want = expected_verdicts.pop_front();
            verdict_count++;
            if (want.tracker_kind <= 3'd4)
                kind_seen[want.tracker_kind]++;
            if (got.detected !== want.detected)
                note_mismatch($sformatf("detected %b, want %b", got.detected, want.detected));
            if (got.tracker_kind !== want.tracker_kind)
                note_mismatch($sformatf("tracker_kind %0d, want %0d",
                                        got.tracker_kind, want.tracker_kind));
            if (got.match_method !== want.match_method)
                note_mismatch($sformatf("match_method %b, want %b",
                                        got.match_method, want.match_method));
            if (got.confidence !== want.confidence)
                note_mismatch($sformatf("confidence %0d, want %0d",
                                        got.confidence, want.confidence));
            if (got.tag_address !== want.tag_address)
                note_mismatch($sformatf("tag_address %h, want %h",
                                        got.tag_address, want.tag_address));
            if (got.tag_strength !== want.tag_strength)
                note_mismatch($sformatf("tag_strength %0d, want %0d",
                                        got.tag_strength, want.tag_strength));
        endtask
    endclass

endpackage

module ble_finder_tag_classifier_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import blftc_pkg::*;
    import blftc_tb_pkg::*;

    localparam int         LongHold = 300;
    localparam bit [6:0]   ScanPlan = 7'b1101101;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;
    logic      i_cfg_wr_en;
    logic      i_cfg_wr_data;

    ad_verdict_tracker verdicts = new();

    logic [7:0]  pkt_bytes[$];
    int unsigned items_sent;
    int unsigned packets_sent;
    int unsigned oversized_sent;
    int unsigned holds_done;
    int unsigned scan_writes;
    bit          hold_req;
    bit          no_gaps;

    ble_finder_tag_classifier_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_data     (i_in_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_data    (o_out_data),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                verdicts.take_item(i_in_data);
            if (o_out_valid && i_out_ready)
                verdicts.compare_verdict(o_out_data);
        end
    end

    // Output side: runs of ready and stall, plus one long hold-off on request
    initial begin
        int run_len;
        bit level;
        i_out_ready = 1'b0;
        run_len     = 0;
        level       = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (LongHold) @(negedge i_clk);
                hold_req = 1'b0;
                holds_done++;
            end else begin
                if (run_len == 0) begin
                    level = !level;
                    if (level)
                        run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                               : $urandom_range(1, 8);
                    else
                        run_len = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60)
                                                                : $urandom_range(1, 3);
                end
                i_out_ready <= level;
                run_len--;
            end
        end
    end

    function automatic int sender_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] mostly(logic [7:0] want);
        return ($urandom_range(0, 9) == 0) ? 8'($urandom) : want;
    endfunction

    function automatic void add_element(logic [7:0] ad_type, int dlen, logic [15:0] id,
                                        logic [7:0] d2, logic [7:0] d3);
        pkt_bytes.push_back(8'(dlen + 1));
        pkt_bytes.push_back(ad_type);
        for (int i = 0; i < dlen; i++) begin
            case (i)
                0: pkt_bytes.push_back(id[7:0]);
                1: pkt_bytes.push_back(id[15:8]);
                2: pkt_bytes.push_back(d2);
                3: pkt_bytes.push_back(d3);
                default: pkt_bytes.push_back(8'($urandom));
            endcase
        end
    endfunction

    function automatic void add_random_element();
        int         dlen;
        logic [7:0] t;
        case ($urandom_range(0, 9))
            0, 1: begin
                dlen = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : $urandom_range(4, 26);
                add_element(TypeManuf, dlen,
                            ($urandom_range(0, 9) == 0) ? 16'($urandom) : CoIdBeacon,
                            mostly(SepSubtype), mostly(SepLength));
            end
            2: add_element(TypeSvc16, $urandom_range(2, 8), UuidFeed, 8'($urandom), 8'($urandom));
            3: add_element(TypeSvc16, $urandom_range(2, 8), UuidFd5a, 8'($urandom), 8'($urandom));
            4: begin
                case ($urandom_range(0, 5))
                    0, 1: dlen = 24;
                    2, 3: dlen = 36;
                    4: dlen = $urandom_range(4, 40);
                    default: dlen = ($urandom_range(0, 1) ? 24 : 36) +
                                    ($urandom_range(0, 1) ? 1 : -1);
                endcase
                add_element(TypeSvc16, dlen, UuidFeaa, mostly(FeaaFrameType), 8'($urandom));
            end
            5: add_element(TypeSvc16, $urandom_range(0, 6), 16'($urandom),
                           8'($urandom), 8'($urandom));
            6: add_element(8'($urandom), 0, '0, '0, '0);
            7: begin
                case ($urandom_range(0, 3))
                    0: t = TypeManuf;
                    1: t = TypeSvc16;
                    default: t = 8'($urandom);
                endcase
                add_element(t, $urandom_range(0, 10), 16'($urandom), 8'($urandom), 8'($urandom));
            end
            8: add_element(TypeManuf, $urandom_range(0, 6), 16'($urandom),
                           8'($urandom), 8'($urandom));
            default: add_element(TypeSvc16, $urandom_range(0, 3),
                                 $urandom_range(0, 1) ? UuidFeed : UuidFd5a,
                                 8'($urandom), 8'($urandom));
        endcase
    endfunction

    function automatic void build_packet();
        int form;
        int n;
        pkt_bytes.delete();
        form = $urandom_range(0, 99);
        if (form < 60) begin
            repeat ($urandom_range(1, 5)) add_random_element();
            if ($urandom_range(0, 4) == 0) begin
                // zero length terminator followed by bytes that must be ignored
                pkt_bytes.push_back(8'h00);
                repeat ($urandom_range(0, 6)) pkt_bytes.push_back(8'($urandom));
            end else if ($urandom_range(0, 5) == 0 && pkt_bytes.size() > 1) begin
                n = pkt_bytes.size() - 1;
                if (n > 6)
                    n = 6;
                repeat ($urandom_range(1, n)) void'(pkt_bytes.pop_back());
            end
        end else if (form < 75) begin
            // service entries around the entry limit, a signature at the end
            repeat ($urandom_range(9, 14))
                add_element(TypeSvc16, $urandom_range(2, 3), 16'($urandom), 8'($urandom), '0);
            add_element(TypeSvc16, 4, $urandom_range(0, 1) ? UuidFeed : UuidFd5a,
                        8'($urandom), 8'($urandom));
        end else begin
            repeat ($urandom_range(1, 30)) pkt_bytes.push_back(8'($urandom));
        end
    endfunction

    // Filler elements up to around the size bound, then signatures straddling it
    function automatic void build_oversized();
        int target;
        pkt_bytes.delete();
        target = $urandom_range(235, 262);
        while (pkt_bytes.size() < target)
            add_element(8'h09, $urandom_range(10, 40), 16'($urandom), 8'($urandom), 8'($urandom));
        add_element(TypeSvc16, 4, UuidFeed, 8'($urandom), 8'($urandom));
        add_element(TypeManuf, 4, CoIdBeacon, SepSubtype, SepLength);
    endfunction

    task automatic drive_byte(t_in_item it);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic send_packet();
        t_in_item    it;
        logic [63:0] r64;
        foreach (pkt_bytes[i]) begin
            r64                = {$urandom, $urandom};
            it.adv_byte        = pkt_bytes[i];
            it.last_byte       = (i == pkt_bytes.size() - 1);
            it.device_address  = r64[47:0];
            it.signal_strength = 8'($urandom);
            drive_byte(it);
        end
        packets_sent++;
        if (pkt_bytes.size() > PacketLimit)
            oversized_sent++;
    endtask

    // Only between packets, once every verdict has drained
    task automatic set_scan(bit v);
        i_in_valid <= 1'b0;
        while (verdicts.expected_verdicts.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        verdicts.scan_on = v;
        scan_writes++;
    endtask

    initial begin
        t_in_item it;
        int       phase_end;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = 1'b0;
        hold_req      = 1'b0;
        no_gaps       = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        set_scan(1'b1);

        // separated beacon
        pkt_bytes = '{8'h05, 8'hFF, 8'h4C, 8'h00, 8'h12, 8'h19};
        send_packet();
        // zero length byte stops the walk
        pkt_bytes = '{8'h00, 8'h03};
        send_packet();
        // empty-data element, then a FEED entry
        pkt_bytes = '{8'h01, 8'h16, 8'h05, 8'h16, 8'hED, 8'hFE, 8'h00, 8'h00};
        send_packet();
        // FD5A entry cut off by the end of the packet
        pkt_bytes = '{8'h05, 8'h16, 8'h5A, 8'hFD};
        send_packet();
        it.adv_byte        = 8'hFF;
        it.last_byte       = 1'b1;
        it.device_address  = '1;
        it.signal_strength = -8'sd128;
        drive_byte(it);
        it.adv_byte        = 8'h00;
        it.device_address  = '0;
        it.signal_strength = 8'sd127;
        drive_byte(it);

        for (int ph = 0; ph < 7; ph++) begin
            set_scan(ScanPlan[ph]);
            no_gaps = (ph == 2 || ph == 5);
            if (ph == 2)
                hold_req = 1'b1;
            phase_end = items_sent + 280;
            if (ph == 1 || ph == 4) begin
                build_oversized();
                send_packet();
            end
            while (items_sent < phase_end) begin
                build_packet();
                send_packet();
            end
        end

        i_in_valid <= 1'b0;
        while (verdicts.expected_verdicts.size() != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);

        $display("Streamed %0d bytes in %0d packets (%0d past the size bound), %0d scan writes",
                 items_sent, packets_sent, oversized_sent, scan_writes);
        $display("Verdicts %0d: beacon %0d, FEED %0d, FD5A %0d, FEAA %0d, none %0d; holds %0d",
                 verdicts.verdict_count, verdicts.kind_seen[1], verdicts.kind_seen[2],
                 verdicts.kind_seen[3], verdicts.kind_seen[4], verdicts.kind_seen[0], holds_done);
        if (verdicts.mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
